// File: sv/slbp_pkg.sv
// Package for the status LED blink pattern block.
// Holds the mode codes, item types, acknowledge counts and the blink pattern table.
// Depends on nothing.
`default_nettype none

package slbp_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    MODE_INTERNET_OK  = 3'd0,
    MODE_OFFLINE      = 3'd1,
    MODE_NO_MQTT      = 3'd2,
    MODE_UNREGISTERED = 3'd3,
    MODE_BATTERY_LOW  = 3'd4,
    MODE_VOLUME       = 3'd5,
    MODE_TRANSACTION  = 3'd6,
    MODE_ERROR        = 3'd7
  } mode_t;

  localparam int unsigned PHASE_W = 4;
  localparam int unsigned ACK_W   = 3;
  localparam int unsigned CODE_W  = 4;

  localparam logic [ACK_W-1:0] VOLUME_ACKS      = 3'd2;
  localparam logic [ACK_W-1:0] TRANSACTION_ACKS = 3'd4;

  typedef struct packed {
    opcode_t             opcode;
    logic [CODE_W-1:0]   mode_code;
  } item_t;

  typedef struct packed {
    logic led_on;
    logic status;
  } result_t;

  function automatic logic pattern_level(input mode_t mode, input logic [PHASE_W-1:0] phase);
    logic lvl;
    lvl = 1'b0;
    case (mode)
      MODE_INTERNET_OK:  lvl = 1'b1;
      MODE_OFFLINE:      lvl = ~phase[PHASE_W-1];
      MODE_NO_MQTT:      lvl = ~phase[0];
      MODE_UNREGISTERED: lvl = (phase == 4'd0) || (phase == 4'd2);
      MODE_BATTERY_LOW:  lvl = (phase == 4'd0) || (phase == 4'd2) || (phase == 4'd4);
      MODE_ERROR:        lvl = ~phase[0];
      default:           lvl = 1'b0;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

// File: sv/slbp_in_reg.sv
// Input register stage of the status LED blink pattern block.
// Captures one item from the input channel and holds it until the core takes it.
// Depends on slbp_pkg.
`default_nettype none

module slbp_in_reg
  import slbp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire item_t in_item,
  input  wire logic  take,
  output logic       stage_vld,
  output item_t      stage_item
);

  logic  stage_vld_r;
  logic  stage_vld_nxt;
  item_t stage_item_r;
  logic  accept;

  assign in_stall = stage_vld_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    stage_vld_nxt = stage_vld_r;
    if (accept) begin
      stage_vld_nxt = 1'b1;
    end else if (take) begin
      stage_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item_r <= in_item;
    end
  end

  assign stage_vld  = stage_vld_r;
  assign stage_item = stage_item_r;

endmodule

`default_nettype wire

// File: sv/slbp_core.sv
// Mode state, blink pattern logic and result register of the status LED block.
// Updates the mode, phase and acknowledge count as each item passes to the result register.
// Depends on slbp_pkg.
`default_nettype none

module slbp_core
  import slbp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  stage_vld,
  input  wire item_t stage_item,
  output logic       take,
  output logic       out_valid,
  input  wire logic  out_stall,
  output result_t    out_result
);

  mode_t              cur_mode_r, cur_mode_nxt;
  mode_t              base_mode_r, base_mode_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [ACK_W-1:0]   ack_left_r, ack_left_nxt;
  logic [ACK_W-1:0]   ack_dec;
  logic               out_vld_r, out_vld_nxt;
  result_t            result_r, result_nxt;
  mode_t              req_mode;

  assign take     = stage_vld && (!out_vld_r || !out_stall);
  assign req_mode = mode_t'(stage_item.mode_code[2:0]);
  assign ack_dec  = ack_left_r - 3'd1;

  always_comb begin
    cur_mode_nxt  = cur_mode_r;
    base_mode_nxt = base_mode_r;
    phase_nxt     = phase_r;
    ack_left_nxt  = ack_left_r;
    result_nxt    = '0;
    if (stage_item.opcode == OP_SET) begin
      if (stage_item.mode_code[CODE_W-1]) begin
        result_nxt.status = 1'b1;
      end else begin
        cur_mode_nxt = req_mode;
        phase_nxt    = '0;
        case (req_mode)
          MODE_VOLUME:      ack_left_nxt = VOLUME_ACKS;
          MODE_TRANSACTION: ack_left_nxt = TRANSACTION_ACKS;
          default: begin
            base_mode_nxt = req_mode;
            ack_left_nxt  = '0;
          end
        endcase
      end
    end else if (ack_left_r != '0) begin
      result_nxt.led_on = ~ack_left_r[0];
      ack_left_nxt      = ack_dec;
      if (ack_dec == '0) begin
        cur_mode_nxt = base_mode_r;
        phase_nxt    = '0;
      end
    end else begin
      result_nxt.led_on = pattern_level(cur_mode_r, phase_r);
      phase_nxt         = phase_r + 4'd1;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r && out_stall;
    if (take) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mode_r  <= MODE_OFFLINE;
      base_mode_r <= MODE_OFFLINE;
      phase_r     <= '0;
      ack_left_r  <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (take) begin
        cur_mode_r  <= cur_mode_nxt;
        base_mode_r <= base_mode_nxt;
        phase_r     <= phase_nxt;
        ack_left_r  <= ack_left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_result = result_r;

endmodule

`default_nettype wire

// File: sv/status_led_blink_pattern.sv
// Top level of the status LED blink pattern block.
// Joins the input register stage and the core with its result register.
// Depends on slbp_pkg, slbp_in_reg and slbp_core.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  in_opcode, in_mode_code
//   out      out_valid / out_stall out_led_on, out_status
//
// The core takes an item from the input register and registers its result,
// and one item is accepted in every cycle while the output side does not stall.
// The rate is set by the single update of the mode, phase and acknowledge registers.
// Reset is synchronous and active low; it selects the offline mode and clears both stages.
// A stalled output keeps its result; one more item waits in the input register,
// and only then is in_stall raised.
`default_nettype none

module status_led_blink_pattern
  import slbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_opcode,
  input  wire logic [CODE_W-1:0] in_mode_code,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_led_on,
  output logic                   out_status
);

  item_t   in_item;
  item_t   stage_item;
  logic    stage_vld;
  logic    take;
  result_t out_result;

  assign in_item.opcode    = opcode_t'(in_opcode);
  assign in_item.mode_code = in_mode_code;

  slbp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .stage_vld  (stage_vld),
    .stage_item (stage_item)
  );

  slbp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage_vld  (stage_vld),
    .stage_item (stage_item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_led_on = out_result.led_on;
  assign out_status = out_result.status;

  a_reject_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_led_on)
    else $error("A rejected item drove the LED on.");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stage_vld && out_valid && out_stall)
    else $error("Input stalled while a stage was free.");

  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> stage_vld)
    else $error("An accepted item was not held in the input stage.");

endmodule

`default_nettype wire
